>>> hw/rtl/crti_pkg.sv
// Shared types and constants of the Catmull-Rom table interpolator.
// No dependencies; the divider, the root unit and the interpolator import this package.
`default_nettype none

package crti_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // knot and parameter values (raw Q16.16, signed)
    localparam int KW    = 36;
    localparam int KN_W  = 33;
    // divider: |num| << 16 over a positive divisor
    localparam int DVD_W = KW + 16;
    localparam int DVS_W = KW;
    // root unit
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;

    localparam logic [KN_W-1:0] ONE_Q = KN_W'(65536);
    localparam logic [29:0]     W_MAX = 30'h3FFF_FFFF;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_SWAP  = 1'b0;
    localparam logic REG_ALPHA = 1'b1;

    localparam logic [1:0] ALPHA_UNIFORM = 2'd0;
    localparam logic [1:0] ALPHA_CENTRIP = 2'd1;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_FEW   = 3'd2,
        ST_EDGE  = 3'd3,
        ST_FULL  = 3'd4,
        ST_ZDIV  = 3'd5
    } status_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } point_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/crti_in_if.sv
// Input channel of the interpolator: valid/ready plus one item.
// No dependencies.
`default_nettype none

interface crti_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [31:0] coord_a;
    logic signed [31:0] coord_b;

    modport source (output valid, output opcode, output coord_a, output coord_b, input ready);
    modport sink   (input valid, input opcode, input coord_a, input coord_b, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/crti_out_if.sv
// Result channel of the interpolator: valid/ready plus one item.
// No dependencies.
`default_nettype none

interface crti_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic [2:0]         status;

    modport source (output valid, output result_x, output result_y, output status, input ready);
    modport sink   (input valid, input result_x, input result_y, input status, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/crti_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on crti_pkg.
`default_nettype none

module crti_div
    import crti_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output unit_stat_t       stat
);
    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        // dividend bits leave quo_reg at the top while quotient bits enter below
        shifted = {rem_reg, quo_reg[DVD_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(DVD_W);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign stat     = '{busy: busy_reg, done: done_reg};

endmodule

`default_nettype wire

>>> hw/rtl/crti_sqrt.sv
// Integer square root (floor), two radicand bits per cycle.
// Depends on crti_pkg.
`default_nettype none

module crti_sqrt
    import crti_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic [ROOT_W-1:0] root,
    output unit_stat_t        stat
);
    localparam int CW  = $clog2(ROOT_W + 1);
    localparam int RMW = ROOT_W + 2;

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [RMW-1:0]    rem_reg, rem_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [RMW+1:0]    rem_sh;
    logic [RMW+1:0]    trial;
    logic [RMW+1:0]    diff;

    always_comb
    begin
        rad_next  = rad_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        diff   = rem_sh - trial;
        if (busy_reg)
        begin
            if (rem_sh >= trial)
            begin
                rem_next  = diff[RMW-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[RMW-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            rad_next  = radicand;
            root_next = '0;
            rem_next  = '0;
            cnt_next  = CW'(ROOT_W);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign root = root_reg;
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

`default_nettype wire

>>> hw/rtl/catmull_rom_table_interpolator.sv
// Point table with Catmull-Rom interpolation in signed Q16.16. One item at a time: an add
// walks down the table from its end, moving larger entries up by one; a query walks the
// table to find its segment and, if it has one, takes knot steps (one root each for
// chordal, two for centripetal, none for uniform), 6 quotients on the shared divider
// and the lerps. Results wait in an output register while the next item is taken.
// Depends on crti_pkg, crti_in_if, crti_out_if, crti_div, crti_sqrt.
`default_nettype none

module catmull_rom_table_interpolator
    import crti_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [1:0] cfg_data,
    crti_in_if.sink    in_ch,
    crti_out_if.source out_ch
);

    typedef enum logic [4:0] {
        S_IDLE, S_ADD_RD, S_ADD_CHK, S_ADD_PUT,
        S_Q_RD0, S_Q_CHK0, S_Q_RDL, S_Q_CHKL, S_Q_SRD, S_Q_SCHK, S_Q_LOAD,
        S_K_PREP, S_K_SQX, S_K_SQY, S_K_SUM, S_K_RT1, S_K_RT1W, S_K_RT2W, S_K_END,
        S_U_DIV, S_U_WAIT, S_U_MUL, S_U_T,
        S_W_DIV, S_W_WAIT, S_L_MUL, S_L_ADD, S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               swap_reg, swap_next;
    logic [1:0]         alpha_reg, alpha_next;
    point_t             pt_reg, pt_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic signed [31:0] prev_reg, prev_next;
    logic [IDX_W-1:0]   seg_reg, seg_next;
    logic [2:0]         ld_reg, ld_next;
    point_t             p_reg [4];
    point_t             p_next [4];
    logic [1:0]         k_reg, k_next;
    logic [KN_W-1:0]    kn_reg [3];
    logic [KN_W-1:0]    kn_next [3];
    logic [30:0]        ux_reg, ux_next, uy_reg, uy_next;
    logic               sh_reg, sh_next;
    logic [62:0]        sq_reg, sq_next;
    logic [16:0]        u_reg, u_next;
    logic signed [KW-1:0] t_reg, t_next, t2_reg, t2_next, t3_reg, t3_next, t4_reg, t4_next;
    logic [29:0]        wmag_reg, wmag_next, w23m_reg, w23m_next;
    logic               wneg_reg, wneg_next, w23n_reg, w23n_next;
    logic [2:0]         stage_reg, stage_next;
    logic               lx_reg, lx_next;
    point_t             a1_reg, a1_next, a2_reg, a2_next, a3_reg, a3_next;
    point_t             b1_reg, b1_next, b2_reg, b2_next;
    logic signed [31:0] res_x_reg, res_x_next, res_y_reg, res_y_next;
    status_t            res_st_reg, res_st_next;
    logic signed [31:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    status_t            out_st_reg, out_st_next;
    logic               out_valid_reg, out_valid_next;
    logic [64:0]        mul_reg, mul_next;

    // point memory
    point_t             mem [MAX_POINTS];
    point_t             rd_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr, mem_raddr;
    point_t             mem_wdata;

    // shared units
    logic [33:0]        mul_a;
    logic [30:0]        mul_b;
    logic               div_start;
    logic [DVD_W-1:0]   div_dvd, div_quo;
    logic [DVS_W-1:0]   div_dvs;
    unit_stat_t         div_stat;
    logic               sq_start;
    logic [ROOT_W-1:0]  sq_root;
    unit_stat_t         sq_stat;

    crti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    crti_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand ({1'b0, sq_reg}),
        .root     (sq_root),
        .stat     (sq_stat)
    );

    assign mul_next = mul_a * mul_b;

    // knot step operands: points k and k+1
    point_t          kp_a, kp_b;
    logic [32:0]     kdx, kdy, kux, kuy;
    logic            kbig;
    logic [KN_W-1:0] kdist;

    always_comb
    begin
        kp_a = p_reg[k_reg];
        kp_b = p_reg[2'(k_reg + 2'd1)];
        kdx  = {kp_b.x[31], kp_b.x} - {kp_a.x[31], kp_a.x};
        kdy  = {kp_b.y[31], kp_b.y} - {kp_a.y[31], kp_a.y};
        kux  = kdx[32] ? 33'(-kdx) : kdx;
        kuy  = kdy[32] ? 33'(-kdy) : kdy;
        kbig = kux[32] | kux[31] | kuy[32] | kuy[31];
        kdist = sh_reg ? {sq_root, 1'b0} : {1'b0, sq_root};
    end

    // weight numerator and denominator per pyramid step
    logic signed [KW-1:0] w_num, w_den;
    logic [KW-1:0]        w_nmag;

    always_comb
    begin
        case (stage_reg)
            3'd0:
            begin
                w_num = t_reg;
                w_den = t2_reg;
            end
            3'd2:
            begin
                w_num = t_reg - t3_reg;
                w_den = t4_reg - t3_reg;
            end
            3'd3:
            begin
                w_num = t_reg;
                w_den = t3_reg;
            end
            3'd4:
            begin
                w_num = t_reg - t2_reg;
                w_den = t4_reg - t2_reg;
            end
            default:
            begin
                w_num = t_reg - t2_reg;
                w_den = t3_reg - t2_reg;
            end
        endcase
        w_nmag = w_num[KW-1] ? KW'(-w_num) : KW'(w_num);
    end

    // lerp operands and result
    point_t             lp_lo, lp_hi;
    logic signed [31:0] lp_a, lp_b, lp_res;
    logic [32:0]        lp_d, lp_dmag;
    logic               lp_neg;
    logic [50:0]        lp_sum;

    always_comb
    begin
        case (stage_reg)
            3'd0:
            begin
                lp_lo = p_reg[0];
                lp_hi = p_reg[1];
            end
            3'd1:
            begin
                lp_lo = p_reg[1];
                lp_hi = p_reg[2];
            end
            3'd2:
            begin
                lp_lo = p_reg[2];
                lp_hi = p_reg[3];
            end
            3'd3:
            begin
                lp_lo = a1_reg;
                lp_hi = a2_reg;
            end
            3'd4:
            begin
                lp_lo = a2_reg;
                lp_hi = a3_reg;
            end
            default:
            begin
                lp_lo = b1_reg;
                lp_hi = b2_reg;
            end
        endcase
        lp_a    = lx_reg ? lp_lo.y : lp_lo.x;
        lp_b    = lx_reg ? lp_hi.y : lp_hi.x;
        lp_d    = {lp_b[31], lp_b} - {lp_a[31], lp_a};
        lp_dmag = lp_d[32] ? 33'(-lp_d) : lp_d;
        lp_neg  = lp_d[32] ^ wneg_reg;
        if (lp_neg)
            lp_sum = {{19{lp_a[31]}}, lp_a} - {2'b00, mul_reg[64:16]};
        else
            lp_sum = {{19{lp_a[31]}}, lp_a} + {2'b00, mul_reg[64:16]};
        // saturate to 32-bit signed
        if (lp_sum[50:31] == '0 || lp_sum[50:31] == '1)
            lp_res = lp_sum[31:0];
        else if (lp_sum[50])
            lp_res = 32'sh8000_0000;
        else
            lp_res = 32'sh7FFF_FFFF;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        swap_next      = swap_reg;
        alpha_next     = alpha_reg;
        pt_next        = pt_reg;
        idx_next       = idx_reg;
        prev_next      = prev_reg;
        seg_next       = seg_reg;
        ld_next        = ld_reg;
        p_next         = p_reg;
        k_next         = k_reg;
        kn_next        = kn_reg;
        ux_next        = ux_reg;
        uy_next        = uy_reg;
        sh_next        = sh_reg;
        sq_next        = sq_reg;
        u_next         = u_reg;
        t_next         = t_reg;
        t2_next        = t2_reg;
        t3_next        = t3_reg;
        t4_next        = t4_reg;
        wmag_next      = wmag_reg;
        wneg_next      = wneg_reg;
        w23m_next      = w23m_reg;
        w23n_next      = w23n_reg;
        stage_next     = stage_reg;
        lx_next        = lx_reg;
        a1_next        = a1_reg;
        a2_next        = a2_reg;
        a3_next        = a3_reg;
        b1_next        = b1_reg;
        b2_next        = b2_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_st_next    = res_st_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_st_next    = out_st_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[IDX_W-1:0];
        mem_wdata      = pt_reg;
        mem_raddr      = '0;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_dvd        = '0;
        div_dvs        = '0;
        sq_start       = 1'b0;

        if (cfg_we)
        begin
            if (cfg_index == REG_SWAP)
                swap_next = cfg_data[0];
            else
                alpha_next = cfg_data;
        end

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    res_x_next  = '0;
                    res_y_next  = '0;
                    res_st_next = ST_OK;
                    idx_next    = count_reg;
                    if (in_ch.opcode == OP_ADD)
                    begin
                        pt_next.x = swap_reg ? in_ch.coord_b : in_ch.coord_a;
                        pt_next.y = swap_reg ? in_ch.coord_a : in_ch.coord_b;
                        if (count_reg >= CNT_W'(MAX_POINTS))
                        begin
                            res_st_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else if (count_reg == '0)
                            state_next = S_ADD_PUT;
                        else
                            state_next = S_ADD_RD;
                    end
                    else
                    begin
                        pt_next.x = in_ch.coord_a;
                        if (count_reg == '0)
                        begin
                            res_st_next = ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                            state_next = S_Q_RD0;
                    end
                end
            end

            // walk down from the end, moving larger entries up by one
            S_ADD_RD:
            begin
                mem_raddr  = IDX_W'(idx_reg - CNT_W'(1));
                state_next = S_ADD_CHK;
            end
            S_ADD_CHK:
            begin
                if (idx_reg == count_reg && rd_reg.x == pt_reg.x)
                    state_next = S_DONE;
                else if (rd_reg.x > pt_reg.x)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = rd_reg;
                    idx_next  = idx_reg - CNT_W'(1);
                    state_next = (idx_reg == CNT_W'(1)) ? S_ADD_PUT : S_ADD_RD;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_ADD_PUT:
            begin
                mem_we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
                state_next = S_DONE;
            end

            S_Q_RD0:
            begin
                mem_raddr  = '0;
                state_next = S_Q_CHK0;
            end
            S_Q_CHK0:
            begin
                if (pt_reg.x < rd_reg.x)
                begin
                    res_x_next = rd_reg.y;
                    res_y_next = rd_reg.y;
                    state_next = S_DONE;
                end
                else
                    state_next = S_Q_RDL;
            end
            S_Q_RDL:
            begin
                mem_raddr  = IDX_W'(count_reg - CNT_W'(1));
                state_next = S_Q_CHKL;
            end
            S_Q_CHKL:
            begin
                if (pt_reg.x > rd_reg.x)
                begin
                    res_x_next = rd_reg.y;
                    res_y_next = rd_reg.y;
                    state_next = S_DONE;
                end
                else if (count_reg < CNT_W'(4))
                begin
                    res_st_next = ST_FEW;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next   = CNT_W'(1);
                    state_next = S_Q_SRD;
                end
            end

            // segment search over interior segments; prev_reg holds x of idx-1
            S_Q_SRD:
            begin
                mem_raddr  = idx_reg[IDX_W-1:0];
                state_next = S_Q_SCHK;
            end
            S_Q_SCHK:
            begin
                prev_next = rd_reg.x;
                if (idx_reg >= CNT_W'(2) && prev_reg <= pt_reg.x && pt_reg.x <= rd_reg.x)
                begin
                    seg_next   = IDX_W'(idx_reg - CNT_W'(1));
                    ld_next    = '0;
                    state_next = S_Q_LOAD;
                end
                else if (idx_reg == CNT_W'(count_reg - CNT_W'(2)))
                begin
                    res_st_next = ST_EDGE;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_Q_SRD;
                end
            end

            // fetch points s-1 .. s+2, one read a cycle
            S_Q_LOAD:
            begin
                mem_raddr = seg_reg + IDX_W'(ld_reg[1:0]) - IDX_W'(1);
                if (ld_reg != 3'd0)
                    p_next[2'(ld_reg - 3'd1)] = rd_reg;
                ld_next = ld_reg + 3'd1;
                if (ld_reg == 3'd4)
                begin
                    if (p_reg[2].x == p_reg[1].x)
                    begin
                        res_st_next = ST_ZDIV;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        k_next     = '0;
                        state_next = S_K_PREP;
                    end
                end
            end

            S_K_PREP:
            begin
                if (alpha_reg == ALPHA_UNIFORM)
                begin
                    kn_next[k_reg] = ONE_Q;
                    state_next     = S_K_END;
                end
                else
                begin
                    // halve both when either difference reaches 2^31, root doubled later
                    ux_next    = kbig ? kux[31:1] : kux[30:0];
                    uy_next    = kbig ? kuy[31:1] : kuy[30:0];
                    sh_next    = kbig;
                    state_next = S_K_SQX;
                end
            end
            S_K_SQX:
            begin
                mul_a      = {3'b000, ux_reg};
                mul_b      = ux_reg;
                state_next = S_K_SQY;
            end
            S_K_SQY:
            begin
                mul_a      = {3'b000, uy_reg};
                mul_b      = uy_reg;
                sq_next    = mul_reg[62:0];
                state_next = S_K_SUM;
            end
            S_K_SUM:
            begin
                sq_next    = sq_reg + mul_reg[62:0];
                state_next = S_K_RT1;
            end
            S_K_RT1:
            begin
                sq_start   = 1'b1;
                state_next = S_K_RT1W;
            end
            S_K_RT1W:
            begin
                if (sq_stat.done)
                begin
                    if (alpha_reg == ALPHA_CENTRIP)
                    begin
                        sq_next    = 63'({kdist, 16'h0000});
                        sh_next    = 1'b0;
                        state_next = S_K_RT2W;
                    end
                    else
                    begin
                        kn_next[k_reg] = kdist;
                        state_next     = S_K_END;
                    end
                end
            end
            S_K_RT2W:
            begin
                // first cycle starts the second root, done comes later
                if (!sq_stat.busy && !sq_stat.done && sh_reg == 1'b0)
                begin
                    sq_start = 1'b1;
                    sh_next  = 1'b1;
                end
                else if (sq_stat.done)
                begin
                    kn_next[k_reg] = KN_W'(sq_root);
                    state_next     = S_K_END;
                end
            end
            S_K_END:
            begin
                if (kn_reg[k_reg] == '0)
                begin
                    res_st_next = ST_ZDIV;
                    state_next  = S_DONE;
                end
                else if (k_reg == 2'd2)
                begin
                    t2_next    = KW'(kn_reg[0]);
                    t3_next    = KW'(kn_reg[0]) + KW'(kn_reg[1]);
                    t4_next    = KW'(kn_reg[0]) + KW'(kn_reg[1]) + KW'(kn_reg[2]);
                    state_next = S_U_DIV;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_K_PREP;
                end
            end

            S_U_DIV:
            begin
                div_start  = 1'b1;
                div_dvd    = DVD_W'({32'(pt_reg.x - p_reg[1].x), 16'h0000});
                // segment width can reach 2^32-1, so extend it as unsigned
                div_dvs    = DVS_W'({1'b0, 32'(p_reg[2].x - p_reg[1].x)});
                state_next = S_U_WAIT;
            end
            S_U_WAIT:
            begin
                if (div_stat.done)
                begin
                    u_next     = div_quo[16:0];
                    state_next = S_U_MUL;
                end
            end
            S_U_MUL:
            begin
                mul_a      = 34'(kn_reg[1]);
                mul_b      = 31'(u_reg);
                state_next = S_U_T;
            end
            S_U_T:
            begin
                t_next     = t2_reg + KW'(mul_reg[49:16]);
                stage_next = '0;
                state_next = S_W_DIV;
            end

            S_W_DIV:
            begin
                lx_next = 1'b0;
                if (stage_reg == 3'd5)
                begin
                    wmag_next  = w23m_reg;
                    wneg_next  = w23n_reg;
                    state_next = S_L_MUL;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_dvd    = {w_nmag, 16'h0000};
                    div_dvs    = DVS_W'(w_den);
                    wneg_next  = w_num[KW-1];
                    state_next = S_W_WAIT;
                end
            end
            S_W_WAIT:
            begin
                if (div_stat.done)
                begin
                    wmag_next = (div_quo > DVD_W'(W_MAX)) ? W_MAX : div_quo[29:0];
                    if (stage_reg == 3'd1)
                    begin
                        w23m_next = (div_quo > DVD_W'(W_MAX)) ? W_MAX : div_quo[29:0];
                        w23n_next = wneg_reg;
                    end
                    state_next = S_L_MUL;
                end
            end
            S_L_MUL:
            begin
                mul_a      = {1'b0, lp_dmag};
                mul_b      = {1'b0, wmag_reg};
                state_next = S_L_ADD;
            end
            S_L_ADD:
            begin
                case (stage_reg)
                    3'd0:
                        if (lx_reg) a1_next.y = lp_res; else a1_next.x = lp_res;
                    3'd1:
                        if (lx_reg) a2_next.y = lp_res; else a2_next.x = lp_res;
                    3'd2:
                        if (lx_reg) a3_next.y = lp_res; else a3_next.x = lp_res;
                    3'd3:
                        if (lx_reg) b1_next.y = lp_res; else b1_next.x = lp_res;
                    3'd4:
                        if (lx_reg) b2_next.y = lp_res; else b2_next.x = lp_res;
                    default:
                        if (lx_reg) res_y_next = lp_res; else res_x_next = lp_res;
                endcase
                if (!lx_reg)
                begin
                    lx_next    = 1'b1;
                    state_next = S_L_MUL;
                end
                else if (stage_reg == 3'd5)
                    state_next = S_DONE;
                else
                begin
                    stage_next = stage_reg + 3'd1;
                    state_next = S_W_DIV;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_x_next     = res_x_reg;
                    out_y_next     = res_y_reg;
                    out_st_next    = res_st_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            swap_reg      <= 1'b0;
            alpha_reg     <= ALPHA_CENTRIP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            swap_reg      <= swap_next;
            alpha_reg     <= alpha_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pt_reg     <= pt_next;
        idx_reg    <= idx_next;
        prev_reg   <= prev_next;
        seg_reg    <= seg_next;
        ld_reg     <= ld_next;
        p_reg      <= p_next;
        k_reg      <= k_next;
        kn_reg     <= kn_next;
        ux_reg     <= ux_next;
        uy_reg     <= uy_next;
        sh_reg     <= sh_next;
        sq_reg     <= sq_next;
        u_reg      <= u_next;
        t_reg      <= t_next;
        t2_reg     <= t2_next;
        t3_reg     <= t3_next;
        t4_reg     <= t4_next;
        wmag_reg   <= wmag_next;
        wneg_reg   <= wneg_next;
        w23m_reg   <= w23m_next;
        w23n_reg   <= w23n_next;
        stage_reg  <= stage_next;
        lx_reg     <= lx_next;
        a1_reg     <= a1_next;
        a2_reg     <= a2_next;
        a3_reg     <= a3_next;
        b1_reg     <= b1_next;
        b2_reg     <= b2_next;
        res_x_reg  <= res_x_next;
        res_y_reg  <= res_y_next;
        res_st_reg <= res_st_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
        out_st_reg <= out_st_next;
        mul_reg    <= mul_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_reg <= mem[mem_raddr];
    end

    assign in_ch.ready     = (state_reg == S_IDLE);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.result_x = out_x_reg;
    assign out_ch.result_y = out_y_reg;
    assign out_ch.status   = out_st_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond table size");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> (count_reg == CNT_W'($past(count_reg) + CNT_W'(1))))
        else $error("point count moved by other than one");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_sqrt_start: assert property (@(posedge clk) disable iff (!rst_n)
        sq_start |-> !sq_stat.busy)
        else $error("root unit started while busy");

    a_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_ADD_CHK || state_reg == S_ADD_PUT))
        else $error("table written outside an add");

endmodule

`default_nettype wire

>>> tb/crti_tb_pkg.sv
// Shared testbench definitions for the interpolator bench.
// Depends on crti_pkg.
`timescale 1ns / 1ps

package crti_tb_pkg;
    import crti_pkg::*;

    typedef struct {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        status_t            st;
    } interp_result_t;
endpackage

>>> tb/crti_checker.sv
// Watches both channels, predicts every result from a private copy of the point
// table and compares field by field. Depends on crti_pkg, crti_tb_pkg and the channels.
`timescale 1ns / 1ps

module crti_checker
    import crti_pkg::*;
    import crti_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data,
    crti_in_if          in_ch,
    crti_out_if         out_ch,
    output int          fail_count,
    output int          pending_count
);
    longint         tab_x [MAX_POINTS];
    longint         tab_y [MAX_POINTS];
    int             n_pts;
    logic           swap_mode;
    logic [1:0]     knot_mode;
    interp_result_t pending_results[$];

    assign pending_count = pending_results.size();

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint step_len(longint ax, longint ay, longint bx, longint by);
        logic [63:0] ux;
        logic [63:0] uy;
        logic [63:0] d;
        int          sh;
        ux = mag(bx - ax);
        uy = mag(by - ay);
        sh = 0;
        if (knot_mode == ALPHA_UNIFORM) return 65536;
        if (ux >= 64'd2147483648 || uy >= 64'd2147483648)
        begin
            ux = ux >> 1;
            uy = uy >> 1;
            sh = 1;
        end
        d = int_root(ux * ux + uy * uy) << sh;
        if (knot_mode == ALPHA_CENTRIP) return longint'(int_root(d << 16));
        return longint'(d);
    endfunction

    function automatic longint blend_weight(longint num, longint den);
        longint q;
        q = (num * 65536) / den;
        if (q > longint'(W_MAX)) q = W_MAX;
        if (q < -longint'(W_MAX)) q = -longint'(W_MAX);
        return q;
    endfunction

    function automatic longint mix(longint a, longint b, longint w);
        longint      d;
        logic [63:0] q;
        d = b - a;
        q = (64'(mag(d)) * 64'(mag(w))) >> 16;
        return clamp32(((d < 0) != (w < 0)) ? a - longint'(q) : a + longint'(q));
    endfunction

    function automatic status_t insert_point(longint px, longint py);
        int p;
        if (n_pts >= MAX_POINTS) return ST_FULL;
        p = 0;
        while (p < n_pts && tab_x[p] <= px) p++;
        if (p == n_pts && n_pts > 0 && tab_x[n_pts-1] == px) return ST_OK;
        for (int i = n_pts; i > p; i--)
        begin
            tab_x[i] = tab_x[i-1];
            tab_y[i] = tab_y[i-1];
        end
        tab_x[p] = px;
        tab_y[p] = py;
        n_pts++;
        return ST_OK;
    endfunction

    function automatic interp_result_t spline_at(longint x);
        interp_result_t r;
        int     s;
        longint k12, k23, k34, t2, t3, t4, t, u, w;
        longint a1x, a1y, a2x, a2y, a3x, a3y, b1x, b1y, b2x, b2y;
        r.rx = 0;
        r.ry = 0;
        r.st = ST_OK;
        if (n_pts == 0)
        begin
            r.st = ST_EMPTY;
            return r;
        end
        if (x < tab_x[0])
        begin
            r.rx = tab_y[0];
            r.ry = tab_y[0];
            return r;
        end
        if (x > tab_x[n_pts-1])
        begin
            r.rx = tab_y[n_pts-1];
            r.ry = tab_y[n_pts-1];
            return r;
        end
        if (n_pts < 4)
        begin
            r.st = ST_FEW;
            return r;
        end
        s = 0;
        for (int i = 1; i + 2 < n_pts; i++)
            if (tab_x[i] <= x && x <= tab_x[i+1])
            begin
                s = i;
                break;
            end
        if (s == 0)
        begin
            r.st = ST_EDGE;
            return r;
        end
        if (tab_x[s+1] == tab_x[s])
        begin
            r.st = ST_ZDIV;
            return r;
        end
        k12 = step_len(tab_x[s-1], tab_y[s-1], tab_x[s], tab_y[s]);
        k23 = step_len(tab_x[s], tab_y[s], tab_x[s+1], tab_y[s+1]);
        k34 = step_len(tab_x[s+1], tab_y[s+1], tab_x[s+2], tab_y[s+2]);
        if (k12 == 0 || k23 == 0 || k34 == 0)
        begin
            r.st = ST_ZDIV;
            return r;
        end
        t2 = k12;
        t3 = t2 + k23;
        t4 = t3 + k34;
        u = ((x - tab_x[s]) * 65536) / (tab_x[s+1] - tab_x[s]);
        t = t2 + longint'((64'(u) * 64'(k23)) >> 16);
        w = blend_weight(t, t2);
        a1x = mix(tab_x[s-1], tab_x[s], w);
        a1y = mix(tab_y[s-1], tab_y[s], w);
        w = blend_weight(t - t2, t3 - t2);
        a2x = mix(tab_x[s], tab_x[s+1], w);
        a2y = mix(tab_y[s], tab_y[s+1], w);
        w = blend_weight(t - t3, t4 - t3);
        a3x = mix(tab_x[s+1], tab_x[s+2], w);
        a3y = mix(tab_y[s+1], tab_y[s+2], w);
        w = blend_weight(t, t3);
        b1x = mix(a1x, a2x, w);
        b1y = mix(a1y, a2y, w);
        w = blend_weight(t - t2, t4 - t2);
        b2x = mix(a2x, a3x, w);
        b2y = mix(a2y, a3y, w);
        w = blend_weight(t - t2, t3 - t2);
        r.rx = mix(b1x, b2x, w);
        r.ry = mix(b1y, b2y, w);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        interp_result_t e;
        if (!rst_n)
        begin
            n_pts = 0;
            swap_mode = 1'b0;
            knot_mode = ALPHA_CENTRIP;
            fail_count = 0;
            pending_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_SWAP) swap_mode = cfg_data[0];
                else knot_mode = cfg_data;
            end
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.opcode == OP_ADD)
                begin
                    e.rx = 0;
                    e.ry = 0;
                    e.st = swap_mode ? insert_point(in_ch.coord_b, in_ch.coord_a)
                                     : insert_point(in_ch.coord_a, in_ch.coord_b);
                end
                else
                    e = spline_at(in_ch.coord_a);
                pending_results = {pending_results, e};
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result item");
                    fail_count++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (out_ch.result_x !== e.rx)
                    begin
                        $error("result_x expected %0d got %0d", e.rx, out_ch.result_x);
                        fail_count++;
                    end
                    if (out_ch.result_y !== e.ry)
                    begin
                        $error("result_y expected %0d got %0d", e.ry, out_ch.result_y);
                        fail_count++;
                    end
                    if (out_ch.status !== e.st)
                    begin
                        $error("status expected %0d got %0d", e.st, out_ch.status);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

>>> tb/testbench.sv
// Stimulus and verdict for the Catmull-Rom table interpolator.
// Depends on crti_pkg, the channel interfaces, crti_checker and the block.
`timescale 1ns / 1ps

module testbench
    import crti_pkg::*;
();

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [1:0] cfg_data;
    int         fail_count;
    int         pending_count;
    int         send_idle_pct;
    int         recv_idle_pct;

    crti_in_if  in_ch();
    crti_out_if out_ch();

    catmull_rom_table_interpolator DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
    );

    crti_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_ADD;
        in_ch.coord_a = 0;
        in_ch.coord_b = 0;
        out_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SWAP;
        cfg_data = 0;
        send_idle_pct = 26;
        recv_idle_pct = 47;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // receiver stalls; a run of ready cycles now and then
    always @(posedge clk)
    begin
        if (rst_n)
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        #400ms;
        $display("FAIL");
        $finish;
    end

    // valid stays up after an accepted item until the next idle cycle or item
    task automatic send_item(logic op, logic signed [31:0] a, logic signed [31:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.coord_a <= a;
        in_ch.coord_b <= b;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_count != 0) @(posedge clk);
        repeat (800) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord(int span);
        if (span == 0) return $urandom();
        return $urandom_range(2 * span) - span;
    endfunction

    // a well-formed set: points added to the kept table, then queries over it
    task automatic table_phase(int npts, int nq, int span);
        for (int i = 0; i < npts; i++)
            send_item(OP_ADD, rand_coord(span), rand_coord(span));
        for (int i = 0; i < nq; i++)
            send_item(OP_QUERY, rand_coord(span), $urandom());
    endtask

    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        // directed: empty, few points, edges, equal x, extremes
        send_item(OP_QUERY, 0, 0);
        send_item(OP_ADD, 32'sh0001_0000, 32'sh0002_0000);
        send_item(OP_ADD, 32'sh0001_0000, 32'sh0005_0000);
        send_item(OP_ADD, 32'sh0003_0000, 32'sh0001_0000);
        send_item(OP_QUERY, 32'sh0002_0000, 0);
        send_item(OP_ADD, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_item(OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(OP_ADD, 32'sh0003_0000, 32'sh0009_0000);
        send_item(OP_QUERY, 32'sh0001_8000, 0);
        send_item(OP_QUERY, 32'sh0001_0000, 0);
        send_item(OP_QUERY, 32'sh8000_0000, 32'shFFFF_FFFF);
        send_item(OP_QUERY, 32'sh7FFF_FFFF, 0);
        send_item(OP_QUERY, 32'sh8000_8000, 0);
        send_item(OP_QUERY, 32'sh0002_8000, 0);
        send_item(OP_ADD, 32'sh0001_0000, 32'sh0002_0000);
        send_item(OP_QUERY, 32'sh0003_0000, 0);
        // sender holds off until all results are back
        drain();
        for (int m = 0; m < 5; m++)
        begin
            write_reg(REG_SWAP, m[0]);
            write_reg(REG_ALPHA, m[1:0]);
            if (m == 2)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 26;
            end
            if (m == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // fill to overflow once, with tiny and full-range spans
            table_phase(m == 1 ? 70 : 6 + $urandom_range(6), 70,
                        m == 3 ? 0 : (m == 2 ? 2000 : 32'h0100_0000));
            send_item(OP_ADD, $urandom(), $urandom());
            send_item(OP_QUERY, $urandom(), $urandom());
            drain();
            // clear by reset is not allowed; keep table and add queries on it
            for (int i = 0; i < 25; i++)
                send_item(OP_QUERY, rand_coord(32'h0100_0000), 0);
            drain();
        end
        drain();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/crti_pkg.sv
hw/rtl/crti_in_if.sv
hw/rtl/crti_out_if.sv
hw/rtl/crti_div.sv
hw/rtl/crti_sqrt.sv
hw/rtl/catmull_rom_table_interpolator.sv
tb/crti_tb_pkg.sv
tb/crti_checker.sv
tb/testbench.sv
